// ===== rtl/hsd_pkg.sv =====
// Shared types, constants and codes of the hash slice distribution block.
package hsd_pkg;

  localparam int unsigned HASH_W    = 48;
  localparam int unsigned GROUP_W   = 3;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned VALUE_W   = 23;
  localparam int unsigned SLICE_W   = 16;
  localparam int unsigned WIDEN_W   = 7;
  localparam int unsigned SHIFT_W   = 5;
  localparam int unsigned RSHIFT_W  = 4;
  localparam int unsigned MASK_W    = 2 * VALUE_W;
  localparam int unsigned LSHIFTS_W = 6 * SHIFT_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = MASK_W;

  // Bit offsets of the seven widening bits for group positions 0 and 1.
  localparam int unsigned WIDEN_LO_POS0 = 32;
  localparam int unsigned WIDEN_LO_POS1 = 39;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [VALUE_W-1:0] MASK_IMM    = 23'h00ffff;
  localparam logic [VALUE_W-1:0] MASK_METER  = 23'h7fffff;
  localparam logic [VALUE_W-1:0] MASK_STATS  = 23'h07ffff;
  localparam logic [VALUE_W-1:0] MASK_ACTION = 23'h3fffff;

  typedef enum logic [CMD_W-1:0] {
    CMD_RAW    = 3'd0,
    CMD_IMM_LO = 3'd1,
    CMD_IMM_HI = 3'd2,
    CMD_METER  = 3'd3,
    CMD_STATS  = 3'd4,
    CMD_ACTION = 3'd5
  } hsd_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORD_ON     = 3'd0,
    REG_EXPAND      = 3'd1,
    REG_G2_SHIFTS   = 3'd2,
    REG_MASKS_01    = 3'd3,
    REG_MASKS_23    = 3'd4,
    REG_MASKS_45    = 3'd5,
    REG_LEFT_SHIFTS = 3'd6
  } hsd_reg_e;

  typedef struct packed {
    logic [1:0]           word_on;
    logic [3:0]           expand;
    logic [7:0]           g2_shifts;
    logic [MASK_W-1:0]    masks_01;
    logic [MASK_W-1:0]    masks_23;
    logic [MASK_W-1:0]    masks_45;
    logic [LSHIFTS_W-1:0] left_shifts;
  } hsd_cfg_t;

  // One classified item waiting for the back end.
  typedef struct packed {
    logic [VALUE_W-1:0] slice;
    logic [GROUP_W-1:0] group;
    logic [CMD_W-1:0]   cmd;
  } hsd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hsd_queue_status_t;

endpackage

// ===== rtl/hsd_front.sv =====
// Front end: accepts items, picks the word and slice and applies widening or right shift.
module hsd_front (
  input  logic                         in_valid_i,
  input  logic [hsd_pkg::HASH_W-1:0]   hash_word_zero_i,
  input  logic [hsd_pkg::HASH_W-1:0]   hash_word_one_i,
  input  logic [hsd_pkg::GROUP_W-1:0]  group_i,
  input  logic                         group_enable_i,
  input  logic [hsd_pkg::CMD_W-1:0]    cmd_i,
  input  hsd_pkg::hsd_cfg_t            cfg_i,
  input  hsd_pkg::hsd_queue_status_t   q_status_i,
  output logic                         in_stall_o,
  output logic                         push_o,
  output hsd_pkg::hsd_entry_t          entry_o
);
  import hsd_pkg::*;

  logic               set;
  logic [1:0]         pos;
  logic               active;
  logic [HASH_W-1:0]  word;
  logic [SLICE_W-1:0] slice16;
  logic [VALUE_W-1:0] slice;

  always_comb begin
    set    = 1'b0;
    pos    = 2'd0;
    active = group_enable_i;
    case (group_i)
      3'd0: begin set = 1'b0; pos = 2'd0; end
      3'd1: begin set = 1'b0; pos = 2'd1; end
      3'd2: begin set = 1'b0; pos = 2'd2; end
      3'd3: begin set = 1'b1; pos = 2'd0; end
      3'd4: begin set = 1'b1; pos = 2'd1; end
      3'd5: begin set = 1'b1; pos = 2'd2; end
      default: active = 1'b0;
    endcase
  end

  always_comb begin
    word = set ? hash_word_one_i : hash_word_zero_i;
    if (!cfg_i.word_on[set]) begin
      word = '0;
    end

    case (pos)
      2'd0:    slice16 = word[SLICE_W-1:0];
      2'd1:    slice16 = word[2*SLICE_W-1:SLICE_W];
      default: slice16 = word[3*SLICE_W-1:2*SLICE_W];
    endcase

    slice = {{WIDEN_W{1'b0}}, slice16};
    case (pos)
      2'd0: begin
        if (cfg_i.expand[{set, 1'b0}]) begin
          slice[VALUE_W-1:SLICE_W] = word[WIDEN_LO_POS0 +: WIDEN_W];
        end
      end
      2'd1: begin
        if (cfg_i.expand[{set, 1'b1}]) begin
          slice[VALUE_W-1:SLICE_W] = word[WIDEN_LO_POS1 +: WIDEN_W];
        end
      end
      default: begin
        slice = {{WIDEN_W{1'b0}},
                 slice16 >> (set ? cfg_i.g2_shifts[7:4] : cfg_i.g2_shifts[3:0])};
      end
    endcase

    // An unused or disabled group reaches the back end as a zero slice.
    if (!active) begin
      slice = '0;
    end
  end

  assign in_stall_o    = q_status_i.full;
  assign push_o        = in_valid_i && !q_status_i.full;
  assign entry_o.slice = slice;
  assign entry_o.group = group_i;
  assign entry_o.cmd   = cmd_i;

endmodule

// ===== rtl/hsd_queue.sv =====
// Small queue of classified items between the front end and the back end.
module hsd_queue #(
  parameter int unsigned Depth = hsd_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  hsd_pkg::hsd_entry_t        entry_i,
  input  logic                       pop_i,
  output hsd_pkg::hsd_entry_t        head_o,
  output hsd_pkg::hsd_queue_status_t status_o
);
  import hsd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  hsd_entry_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);

endmodule

// ===== rtl/hsd_back.sv =====
// Back end: group mask, left shift, result type mask and the output register.
module hsd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hsd_pkg::hsd_cfg_t              cfg_i,
  input  hsd_pkg::hsd_entry_t            head_i,
  input  hsd_pkg::hsd_queue_status_t     q_status_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [hsd_pkg::VALUE_W-1:0]    hash_value_o
);
  import hsd_pkg::*;

  logic [VALUE_W-1:0] group_mask;
  logic [SHIFT_W-1:0] lshift;
  logic [VALUE_W-1:0] shifted;
  logic [VALUE_W-1:0] type_mask;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] value_q, value_d;

  always_comb begin
    group_mask = '0;
    lshift     = '0;
    case (head_i.group)
      3'd0: begin
        group_mask = cfg_i.masks_01[VALUE_W-1:0];
        lshift     = cfg_i.left_shifts[0*SHIFT_W +: SHIFT_W];
      end
      3'd1: begin
        group_mask = cfg_i.masks_01[MASK_W-1:VALUE_W];
        lshift     = cfg_i.left_shifts[1*SHIFT_W +: SHIFT_W];
      end
      3'd2: begin
        group_mask = cfg_i.masks_23[VALUE_W-1:0];
        lshift     = cfg_i.left_shifts[2*SHIFT_W +: SHIFT_W];
      end
      3'd3: begin
        group_mask = cfg_i.masks_23[MASK_W-1:VALUE_W];
        lshift     = cfg_i.left_shifts[3*SHIFT_W +: SHIFT_W];
      end
      3'd4: begin
        group_mask = cfg_i.masks_45[VALUE_W-1:0];
        lshift     = cfg_i.left_shifts[4*SHIFT_W +: SHIFT_W];
      end
      3'd5: begin
        group_mask = cfg_i.masks_45[MASK_W-1:VALUE_W];
        lshift     = cfg_i.left_shifts[5*SHIFT_W +: SHIFT_W];
      end
      default: begin
        group_mask = '0;
        lshift     = '0;
      end
    endcase
  end

  always_comb begin
    case (hsd_cmd_e'(head_i.cmd))
      CMD_IMM_LO, CMD_IMM_HI: type_mask = MASK_IMM;
      CMD_METER:              type_mask = MASK_METER;
      CMD_STATS:              type_mask = MASK_STATS;
      CMD_ACTION:             type_mask = MASK_ACTION;
      default:                type_mask = MASK_METER;
    endcase
  end

  // A shift of 23 or more moves every bit out of the result.
  assign shifted = (head_i.slice & group_mask) << lshift;

  assign pop_o = !q_status_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    value_d     = value_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      value_d     = shifted & type_mask;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = value_q;

endmodule

// ===== rtl/hash_slice_distribution_unit.sv =====
// Top level of the hash slice distribution block: configuration, front, queue and back.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    hash_word_zero_i, hash_word_one_i,
//                                                  group_i, group_enable_i, cmd_i
//   out      output     out_valid_o / out_stall_i  hash_value_o
//   cfg      input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One item is accepted every cycle while the queue has room; its result is held in a queue
// entry and then in the output register before out_valid_o shows it.
// Throughput is one item per cycle while out_stall_i is low, set by the single output register draining.
// Reset clears the configuration registers, the queue pointers and the output valid.
// A stall on the output fills the queue; in_stall_o rises only when it is full.
module hash_slice_distribution_unit #(
  parameter int unsigned QueueDepth = hsd_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hsd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [hsd_pkg::HASH_W-1:0]     hash_word_zero_i,
  input  logic [hsd_pkg::HASH_W-1:0]     hash_word_one_i,
  input  logic [hsd_pkg::GROUP_W-1:0]    group_i,
  input  logic                           group_enable_i,
  input  logic [hsd_pkg::CMD_W-1:0]      cmd_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [hsd_pkg::VALUE_W-1:0]    hash_value_o
);
  import hsd_pkg::*;

  hsd_cfg_t          cfg_q, cfg_d;
  hsd_entry_t        entry;
  hsd_entry_t        head;
  hsd_queue_status_t q_status;
  logic              push;
  logic              pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (hsd_reg_e'(cfg_index_i))
        REG_WORD_ON:     cfg_d.word_on     = cfg_data_i[1:0];
        REG_EXPAND:      cfg_d.expand      = cfg_data_i[3:0];
        REG_G2_SHIFTS:   cfg_d.g2_shifts   = cfg_data_i[7:0];
        REG_MASKS_01:    cfg_d.masks_01    = cfg_data_i[MASK_W-1:0];
        REG_MASKS_23:    cfg_d.masks_23    = cfg_data_i[MASK_W-1:0];
        REG_MASKS_45:    cfg_d.masks_45    = cfg_data_i[MASK_W-1:0];
        REG_LEFT_SHIFTS: cfg_d.left_shifts = cfg_data_i[LSHIFTS_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hsd_front u_front (
    .in_valid_i       (in_valid_i),
    .hash_word_zero_i (hash_word_zero_i),
    .hash_word_one_i  (hash_word_one_i),
    .group_i          (group_i),
    .group_enable_i   (group_enable_i),
    .cmd_i            (cmd_i),
    .cfg_i            (cfg_q),
    .q_status_i       (q_status),
    .in_stall_o       (in_stall_o),
    .push_o           (push),
    .entry_o          (entry)
  );

  hsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  hsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

  a_queue_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("back end popped an empty queue");

  a_no_phantom_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_status.empty && !out_valid_o) |=> !out_valid_o)
    else $error("result appeared with nothing queued");

  a_push_when_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (in_valid_i && !q_status.full))
    else $error("item pushed into a full queue");

endmodule
